### rtl/lkcd_pkg.sv
// Shared types and constants for the LRU keyed cache directory.
// Used by lkcd_store, lkcd_scan and lru_keyed_cache_directory_unit; no dependencies.
package lkcd_pkg;

   // Default geometry handed to the top level parameters.
   localparam int DEF_ENTRIES  = 16;
   localparam int DEF_KEY_BITS = 32;

   // Field widths fixed by the interface.
   localparam int STAMP_W  = 64;
   localparam int CAP_W    = 5;
   localparam int KEY_W    = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request opcodes.
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FAIL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CLEAR  = 2'd3;

   // Summary flags of one directory scan.
   typedef struct packed {
      logic hit;      // a valid entry holds the key
      logic min_ok;   // at least one valid entry was seen
      logic free_ok;  // at least one empty entry was seen
   } scan_flags_type;

endpackage

### rtl/lru_keyed_cache_directory_unit.sv
// Top level of the fully associative LRU cache directory: sequencer, valid bits,
// counters and response register. Depends on lkcd_pkg, lkcd_store and lkcd_scan.
//
//   channel | ports   | direction | word
//   --------+---------+-----------+--------------------------------------------
//   request | req_*   | in        | opcode, key, load_ok
//   result  | rsp_*   | out       | status, slot, evicted, evicted_key, totals
//   control | csr_*   | in        | capacity, always ready
//
// An access word is accepted, then the shared compare unit reads one entry per
// cycle from the single memory read port over all ENTRIES addresses; a drain
// state empties the read pipeline and the finish step decides and writes back.
// A clear word goes from accept to the finish step. Reset empties every entry
// at once and clears the counters and the access clock. req_ready is low while
// a word is in work; a result that is not taken holds the finish step.
module lru_keyed_cache_directory_unit #(
   parameter int ENTRIES  = lkcd_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = lkcd_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [lkcd_pkg::KEY_W-1:0]    req_key,
   input  logic                          req_load_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lkcd_pkg::STATUS_W-1:0] rsp_status,
   output logic [lkcd_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_evicted,
   output logic [lkcd_pkg::KEY_W-1:0]    rsp_evicted_key,
   output logic [lkcd_pkg::COUNT_W-1:0]  rsp_hit_total,
   output logic [lkcd_pkg::COUNT_W-1:0]  rsp_miss_total,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkcd_pkg::CAP_W-1:0]    csr_capacity
);
   import lkcd_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff;
   logic                live_ff;
   logic [IDX_W-1:0]    live_idx_ff;
   logic [CAP_W-1:0]    capacity_ff;
   logic [ENTRIES-1:0]  valid_ff;
   logic [STAMP_W-1:0]  clock_ff;
   logic [COUNT_W-1:0]  hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0]  miss_count_ff, miss_count_in;
   logic                op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                load_ok_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                evicted_ff, evicted_in;
   logic [KEY_W-1:0]    evicted_key_ff, evicted_key_in;

   logic                accept;
   logic                finish;
   logic                wr_en;
   logic                wr_insert;
   logic [IDX_W-1:0]    wr_addr;
   logic [KEY_BITS-1:0] rd_key;
   logic [STAMP_W-1:0]  rd_stamp;

   scan_flags_type      flags;
   logic [IDX_W-1:0]    hit_idx;
   logic [IDX_W-1:0]    min_idx;
   logic [KEY_BITS-1:0] min_key;
   logic [IDX_W-1:0]    free_idx;
   logic [CNT_W-1:0]    used;

   logic [CMP_W-1:0]    cap_ext;
   logic [CMP_W-1:0]    eff_cap;
   logic                full;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_capacity;
      end
   end

   // Request word register.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_opcode;
         key_ff     <= KEY_BITS'(req_key);
         load_ok_ff <= req_load_ok;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == OP_CLEAR) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_DONE;
         S_DONE: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer registers and the read pipeline tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         live_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= (state_ff == S_SCAN);
         if (accept) begin
            cnt_ff <= '0;
         end else if (state_ff == S_SCAN) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      live_idx_ff <= cnt_ff;
   end

   // Key and stamp memory, read in address order during the scan.
   // The entry is written back only at the finish step of an access.
   lkcd_store #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en && finish),
      .wr_addr  (wr_addr),
      .wr_key   (key_ff),
      .wr_stamp (clock_ff),
      .rd_addr  (cnt_ff),
      .rd_key   (rd_key),
      .rd_stamp (rd_stamp)
   );

   // Compare unit fed one entry per cycle.
   lkcd_scan #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .live      (live_ff),
      .idx       (live_idx_ff),
      .ent_valid (valid_ff[live_idx_ff]),
      .ent_key   (rd_key),
      .ent_stamp (rd_stamp),
      .key       (key_ff),
      .flags     (flags),
      .hit_idx   (hit_idx),
      .min_idx   (min_idx),
      .min_key   (min_key),
      .free_idx  (free_idx),
      .used      (used)
   );

   // Effective capacity: zero acts as one, large values stop at the entry count.
   assign cap_ext = CMP_W'(capacity_ff);
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end
   assign full = (CMP_W'(used) >= eff_cap);

   // Decision at the end of a word: result fields, write back and counters.
   always_comb begin
      status_in      = STATUS_CLEAR;
      slot_in        = '0;
      evicted_in     = 1'b0;
      evicted_key_in = '0;
      wr_en          = 1'b0;
      wr_insert      = 1'b0;
      wr_addr        = '0;
      hit_count_in   = hit_count_ff;
      miss_count_in  = miss_count_ff;
      if (op_ff == OP_ACCESS) begin
         if (flags.hit) begin
            status_in    = STATUS_HIT;
            slot_in      = SLOT_W'(hit_idx);
            wr_en        = 1'b1;
            wr_addr      = hit_idx;
            hit_count_in = (hit_count_ff == '1) ? hit_count_ff
                                                : hit_count_ff + COUNT_W'(1);
         end else begin
            miss_count_in = (miss_count_ff == '1) ? miss_count_ff
                                                  : miss_count_ff + COUNT_W'(1);
            if (!load_ok_ff) begin
               status_in = STATUS_FAIL;
            end else begin
               status_in = STATUS_INSERT;
               wr_en     = 1'b1;
               wr_insert = 1'b1;
               if (full && flags.min_ok) begin
                  // Reuse the oldest entry.
                  wr_addr        = min_idx;
                  evicted_in     = 1'b1;
                  evicted_key_in = KEY_W'(min_key);
               end else if (flags.free_ok) begin
                  wr_addr = free_idx;
               end
               slot_in = SLOT_W'(wr_addr);
            end
         end
      end
   end

   // Valid bits, access clock and saturating counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         clock_ff      <= '0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
      end else if (finish) begin
         hit_count_ff  <= hit_count_in;
         miss_count_ff <= miss_count_in;
         if (op_ff == OP_CLEAR) begin
            valid_ff <= '0;
         end else if (wr_insert) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (wr_en) begin
            clock_ff <= clock_ff + STAMP_W'(1);
         end
      end
   end

   // Response register; a new result loads only when the old one is gone.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff      <= status_in;
         slot_ff        <= slot_in;
         evicted_ff     <= evicted_in;
         evicted_key_ff <= evicted_key_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;
   assign rsp_hit_total   = hit_count_ff;
   assign rsp_miss_total  = miss_count_ff;

endmodule

### rtl/lkcd_store.sv
// Key and timestamp memory of the directory, one write and one registered read port.
// Depends on lkcd_pkg.
module lkcd_store #(
   parameter int ENTRIES  = lkcd_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = lkcd_pkg::DEF_KEY_BITS,
   parameter int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [KEY_BITS-1:0]          wr_key,
   input  logic [lkcd_pkg::STAMP_W-1:0] wr_stamp,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [KEY_BITS-1:0]          rd_key,
   output logic [lkcd_pkg::STAMP_W-1:0] rd_stamp
);
   import lkcd_pkg::*;

   logic [KEY_BITS-1:0] key_mem   [ENTRIES];
   logic [STAMP_W-1:0]  stamp_mem [ENTRIES];
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [STAMP_W-1:0]  rd_stamp_ff;

   // Write port: key and stamp of one entry together.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

### rtl/lkcd_scan.sv
// Shared compare unit: looks at one entry per cycle and keeps the running
// hit, oldest-entry, first-free and occupancy results. Depends on lkcd_pkg.
module lkcd_scan #(
   parameter int ENTRIES  = lkcd_pkg::DEF_ENTRIES,
   parameter int KEY_BITS = lkcd_pkg::DEF_KEY_BITS,
   parameter int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int CNT_W    = $clog2(ENTRIES + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         live,
   input  logic [IDX_W-1:0]             idx,
   input  logic                         ent_valid,
   input  logic [KEY_BITS-1:0]          ent_key,
   input  logic [lkcd_pkg::STAMP_W-1:0] ent_stamp,
   input  logic [KEY_BITS-1:0]          key,
   output lkcd_pkg::scan_flags_type     flags,
   output logic [IDX_W-1:0]             hit_idx,
   output logic [IDX_W-1:0]             min_idx,
   output logic [KEY_BITS-1:0]          min_key,
   output logic [IDX_W-1:0]             free_idx,
   output logic [CNT_W-1:0]             used
);
   import lkcd_pkg::*;

   scan_flags_type      flags_ff;
   logic [CNT_W-1:0]    used_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [IDX_W-1:0]    min_idx_ff;
   logic [KEY_BITS-1:0] min_key_ff;
   logic [STAMP_W-1:0]  min_stamp_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic                key_eq;
   logic                stamp_lt;

   // The one key compare and one stamp compare of the unit.
   assign key_eq   = (ent_key == key);
   assign stamp_lt = (ent_stamp < min_stamp_ff);

   // Flags and occupancy restart with every scan.
   always_ff @(posedge clock) begin
      if (reset || start) begin
         flags_ff <= '0;
         used_ff  <= '0;
      end else if (live) begin
         if (ent_valid) begin
            used_ff <= used_ff + CNT_W'(1);
            if (key_eq) begin
               flags_ff.hit <= 1'b1;
            end
            if (!flags_ff.min_ok || stamp_lt) begin
               flags_ff.min_ok <= 1'b1;
            end
         end else begin
            flags_ff.free_ok <= 1'b1;
         end
      end
   end

   // Indices, oldest stamp and its key follow the flags.
   always_ff @(posedge clock) begin
      if (live) begin
         if (ent_valid) begin
            if (key_eq && !flags_ff.hit) begin
               hit_idx_ff <= idx;
            end
            // Strict compare keeps the lowest slot among equal stamps.
            if (!flags_ff.min_ok || stamp_lt) begin
               min_idx_ff   <= idx;
               min_stamp_ff <= ent_stamp;
               min_key_ff   <= ent_key;
            end
         end else if (!flags_ff.free_ok) begin
            free_idx_ff <= idx;
         end
      end
   end

   assign flags    = flags_ff;
   assign hit_idx  = hit_idx_ff;
   assign min_idx  = min_idx_ff;
   assign min_key  = min_key_ff;
   assign free_idx = free_idx_ff;
   assign used     = used_ff;

endmodule
